/* rtl/core/ptbd_pkg.sv */
// Package with shared types and constants of the paletted box downscale core.
package ptbd_pkg;

	localparam int MaxDim = 512;
	localparam int SrcDepth = 65536;
	localparam int SrcAw = $clog2(SrcDepth);
	localparam int DimW = 10;
	localparam int CoordW = 9;
	// Numerator (4*511+3)*512 fits in 20 bits, kept at 21; divisor 4*512 needs 12 bits.
	localparam int NumW = 21;
	localparam int DenW = 12;
	localparam int QuoW = 10;
	localparam int QueueDepth = 4;
	localparam int QueueAw = $clog2(QueueDepth);

	localparam logic [1:0] OpPal = 2'd0;
	localparam logic [1:0] OpSrc = 2'd1;
	localparam logic [1:0] OpPix = 2'd2;
	localparam logic [1:0] OpNop = 2'd3;

	localparam logic [2:0] RegSrcW = 3'd0;
	localparam logic [2:0] RegSrcH = 3'd1;
	localparam logic [2:0] RegDstW = 3'd2;
	localparam logic [2:0] RegDstH = 3'd3;
	localparam logic [2:0] RegMask = 3'd4;
	localparam logic [2:0] RegTrans = 3'd5;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] write_address;
		logic [23:0] write_value;
		logic [8:0]  out_x;
		logic [8:0]  out_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} out_item_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		logic [1:0]        op;
		logic [SrcAw-1:0]  addr;
		logic [23:0]       value;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
	} cmd_t;

	// Clamp a size register into 1..MaxDim.
	function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
		logic [DimW-1:0] r;
		r = v;
		if (v == '0) r = DimW'(1);
		else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
		return r;
	endfunction

endpackage

/* rtl/core/ptbd_front.sv */
// Front part: accepts items, clamps coordinates and queues commands.
module ptbd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ptbd_pkg::in_item_t    in_data,
	input  logic [ptbd_pkg::DimW-1:0] tw,
	input  logic [ptbd_pkg::DimW-1:0] th,
	output logic                  cmd_valid,
	input  logic                  cmd_take,
	output ptbd_pkg::cmd_t        cmd
);

	ptbd_pkg::cmd_t q_mem [ptbd_pkg::QueueDepth];
	logic [ptbd_pkg::QueueAw-1:0] wr_q, rd_q;
	logic [ptbd_pkg::QueueAw:0]   cnt_q;
	ptbd_pkg::cmd_t nc;
	logic [ptbd_pkg::DimW-1:0] xm, ym;
	logic push;

	assign in_stall = (cnt_q == (ptbd_pkg::QueueAw+1)'(ptbd_pkg::QueueDepth));
	assign push = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_mem[rd_q];

	// Classify and clamp the incoming beat.
	always_comb begin
		xm = tw - ptbd_pkg::DimW'(1);
		ym = th - ptbd_pkg::DimW'(1);
		nc.op = in_data.op;
		nc.addr = in_data.write_address[ptbd_pkg::SrcAw-1:0];
		nc.value = in_data.write_value;
		nc.x = ({1'b0, in_data.out_x} > xm) ? xm[ptbd_pkg::CoordW-1:0] : in_data.out_x;
		nc.y = ({1'b0, in_data.out_y} > ym) ? ym[ptbd_pkg::CoordW-1:0] : in_data.out_y;
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= nc;
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (ptbd_pkg::QueueAw+1)'(push) - (ptbd_pkg::QueueAw+1)'(cmd_take);
		end
	end

endmodule

/* rtl/core/ptbd_div.sv */
// Serial restoring divider, one quotient bit per cycle.
module ptbd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ptbd_pkg::NumW-1:0] num,
	input  logic [ptbd_pkg::DenW-1:0] den,
	output logic                      done,
	output logic [ptbd_pkg::QuoW-1:0] quo
);

	logic [ptbd_pkg::NumW-1:0] n_q;
	logic [ptbd_pkg::DenW:0]   rem_q;
	logic [ptbd_pkg::DenW-1:0] d_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic [ptbd_pkg::DenW:0]   sh;

	assign sh = {rem_q[ptbd_pkg::DenW-1:0], n_q[ptbd_pkg::NumW-1]};
	assign quo = n_q[ptbd_pkg::QuoW-1:0];

	// Shift numerator bits into the remainder and build the quotient in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(ptbd_pkg::NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (sh >= {1'b0, d_q}) begin
				rem_q <= sh - {1'b0, d_q};
				n_q <= {n_q[ptbd_pkg::NumW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				n_q <= {n_q[ptbd_pkg::NumW-2:0], 1'b0};
			end
		end
	end

endmodule

/* rtl/core/ptbd_back.sv */
// Back part: store writes, coordinate mapping, texel fetch and averaging.
module ptbd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_take,
	input  ptbd_pkg::cmd_t            cmd,
	input  logic [ptbd_pkg::DimW-1:0] sw,
	input  logic [ptbd_pkg::DimW-1:0] sh,
	input  logic [ptbd_pkg::DimW-1:0] tw,
	input  logic [ptbd_pkg::DimW-1:0] th,
	input  logic                      mask_en,
	input  logic [7:0]                trans_idx,
	output logic                      out_valid,
	input  logic                      out_stall,
	output ptbd_pkg::out_item_t       out_data
);

	typedef enum logic [3:0] {
		IDLE, DIV_GO, DIV_WAIT, ADDR, SRC_RD, SRC_WAIT, PAL_RD, PAL_WAIT, ACC, OUT
	} state_t;

	state_t state_q;
	logic [23:0] pal_mem [256];
	logic [7:0]  src_mem [ptbd_pkg::SrcDepth];
	logic [23:0] pal_rd_q;
	logic [7:0]  src_rd_q;
	logic [ptbd_pkg::SrcAw-1:0] raddr_q;
	logic [7:0]  pidx_q;

	logic [1:0]  k_q;          // which of four coordinates or texels
	logic [ptbd_pkg::CoordW-1:0] x_q, y_q;
	logic [ptbd_pkg::QuoW-1:0] c1_q, c2_q, r1_q, r2_q;
	logic [9:0]  sr_q, sg_q, sb_q;
	logic        clear_q;
	logic        out_v_q;
	ptbd_pkg::out_item_t out_q;

	logic        dstart;
	logic [ptbd_pkg::NumW-1:0] dnum;
	logic [ptbd_pkg::DenW-1:0] dden;
	logic        ddone;
	logic [ptbd_pkg::QuoW-1:0] dquo;
	logic [ptbd_pkg::CoordW+1:0] pos4;
	logic [ptbd_pkg::DimW-1:0] srcd, dstd;
	logic [ptbd_pkg::QuoW-1:0] rsel, csel;

	assign out_valid = out_v_q;
	assign out_data = out_q;
	assign cmd_take = (state_q == IDLE) && cmd_valid && !out_v_q;
	assign dstart = (state_q == DIV_GO);

	// Divider operands for the current coordinate: k bit 1 picks row, bit 0 the 3/4 point.
	always_comb begin
		pos4 = {(k_q[1] ? y_q : x_q), 2'b00} | {ptbd_pkg::CoordW'(0), k_q[0], 1'b1};
		srcd = k_q[1] ? sh : sw;
		dstd = k_q[1] ? th : tw;
		dnum = ptbd_pkg::NumW'(pos4 * srcd);
		dden = {dstd, 2'b00};
		rsel = k_q[1] ? r2_q : r1_q;
		csel = k_q[0] ? c2_q : c1_q;
	end

	ptbd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (cmd_take && cmd.op == ptbd_pkg::OpPal) pal_mem[cmd.addr[7:0]] <= cmd.value;
		if (cmd_take && cmd.op == ptbd_pkg::OpSrc) src_mem[cmd.addr] <= cmd.value[7:0];
		src_rd_q <= src_mem[raddr_q];
		pal_rd_q <= pal_mem[pidx_q];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_v_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (cmd_take && cmd.op == ptbd_pkg::OpPix) begin
						x_q <= cmd.x;
						y_q <= cmd.y;
						k_q <= '0;
						state_q <= DIV_GO;
					end
				end
				DIV_GO: state_q <= DIV_WAIT;
				DIV_WAIT: begin
					if (ddone) begin
						case (k_q)
							2'd0: c1_q <= dquo;
							2'd1: c2_q <= dquo;
							2'd2: r1_q <= dquo;
							default: r2_q <= dquo;
						endcase
						k_q <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? ADDR : DIV_GO;
						sr_q <= '0;
						sg_q <= '0;
						sb_q <= '0;
						clear_q <= 1'b1;
					end
				end
				ADDR: begin
					raddr_q <= ptbd_pkg::SrcAw'(rsel * sw + ptbd_pkg::DimW'(csel));
					state_q <= SRC_RD;
				end
				SRC_RD: state_q <= SRC_WAIT;
				SRC_WAIT: begin
					pidx_q <= src_rd_q;
					if (src_rd_q != trans_idx) clear_q <= 1'b0;
					state_q <= PAL_RD;
				end
				PAL_RD: state_q <= PAL_WAIT;
				PAL_WAIT: state_q <= ACC;
				ACC: begin
					sr_q <= sr_q + 10'(pal_rd_q[7:0]);
					sg_q <= sg_q + 10'(pal_rd_q[15:8]);
					sb_q <= sb_q + 10'(pal_rd_q[23:16]);
					k_q <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? OUT : ADDR;
				end
				OUT: begin
					if (!out_v_q) begin
						out_q.red <= sr_q[9:2];
						out_q.green <= sg_q[9:2];
						out_q.blue <= sb_q[9:2];
						out_q.alpha <= (mask_en && clear_q) ? 8'h00 : 8'hFF;
						out_v_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/palette_texture_box_downscale_core.sv */
// Top level of the paletted image 2x2 box downscale core.
//  channel | direction | handshake      | payload
//  in      | input     | valid / stall  | ptbd_pkg::in_item_t
//  out     | output    | valid / stall  | ptbd_pkg::out_item_t
//  cfg     | input     | valid / ready  | index, data
// Load items are written into the stores as the back part takes them; a
// compute item runs four serial divisions (one quotient bit a cycle) and
// then four source reads and four palette reads before the average.
// Reset clears control state only; the stores hold garbage until written.
// A four-entry queue lets the input take items while the back part works
// or while a finished result waits behind out_stall.
module palette_texture_box_downscale_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ptbd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ptbd_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [9:0]          cfg_data
);

	logic [ptbd_pkg::DimW-1:0] sw_q, sh_q, tw_q, th_q;
	logic        mask_q;
	logic [7:0]  trans_q;
	logic        cmd_valid, cmd_take;
	ptbd_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers, sizes stored already clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= ptbd_pkg::DimW'(1);
			sh_q <= ptbd_pkg::DimW'(1);
			tw_q <= ptbd_pkg::DimW'(1);
			th_q <= ptbd_pkg::DimW'(1);
			mask_q <= 1'b0;
			trans_q <= 8'hFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptbd_pkg::RegSrcW: sw_q <= ptbd_pkg::eff_dim(cfg_data);
				ptbd_pkg::RegSrcH: sh_q <= ptbd_pkg::eff_dim(cfg_data);
				ptbd_pkg::RegDstW: tw_q <= ptbd_pkg::eff_dim(cfg_data);
				ptbd_pkg::RegDstH: th_q <= ptbd_pkg::eff_dim(cfg_data);
				ptbd_pkg::RegMask: mask_q <= cfg_data[0];
				ptbd_pkg::RegTrans: trans_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ptbd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .tw(tw_q), .th(th_q),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	ptbd_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .sw(sw_q), .sh(sh_q), .tw(tw_q), .th(th_q),
		.mask_en(mask_q), .trans_idx(trans_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench for the paletted 2x2 box downscale core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ptbd_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ptbd_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	// Shadow of the configuration registers and the two stores.
	logic [9:0] sh_src_w, sh_src_h, sh_dst_w, sh_dst_h;
	logic sh_mask;
	logic [7:0] sh_trans;
	logic [23:0] pal_mem [256];
	bit pal_set [256];
	logic [7:0] src_mem [ptbd_pkg::SrcDepth];
	bit src_set [ptbd_pkg::SrcDepth];
	int unsigned tex_addr [4];

	ptbd_pkg::out_item_t pix_expected [$];
	int errors = 0;
	int sent = 0;
	bit quiet = 1'b0;

	palette_texture_box_downscale_core u_top (.*);

	always #5 clk = ~clk;

	// Force a size register into 1..MaxDim.
	function automatic int unsigned fit_dim(logic [9:0] v);
		if (v == 0) return 1;
		if (v > ptbd_pkg::MaxDim) return ptbd_pkg::MaxDim;
		return 32'(v);
	endfunction

	function automatic int unsigned map_pos(int unsigned p, int unsigned q,
			int unsigned s, int unsigned d);
		return ((p * 4 + q) * s) / (d * 4);
	endfunction

	// Source addresses of the four texels behind output pixel (x, y).
	task automatic sample_addrs(input logic [8:0] x, input logic [8:0] y);
		int unsigned sw, sh, tw, th, cx, cy, c1, c2, r1, r2;
		sw = fit_dim(sh_src_w);
		sh = fit_dim(sh_src_h);
		tw = fit_dim(sh_dst_w);
		th = fit_dim(sh_dst_h);
		cx = (x > tw - 1) ? tw - 1 : 32'(x);
		cy = (y > th - 1) ? th - 1 : 32'(y);
		c1 = map_pos(cx, 1, sw, tw);
		c2 = map_pos(cx, 3, sw, tw);
		r1 = map_pos(cy, 1, sh, th);
		r2 = map_pos(cy, 3, sh, th);
		tex_addr[0] = (r1 * sw + c1) % ptbd_pkg::SrcDepth;
		tex_addr[1] = (r1 * sw + c2) % ptbd_pkg::SrcDepth;
		tex_addr[2] = (r2 * sw + c1) % ptbd_pkg::SrcDepth;
		tex_addr[3] = (r2 * sw + c2) % ptbd_pkg::SrcDepth;
	endtask

	// Averaged RGBA of one output pixel from the shadow stores.
	task automatic predict_pixel(input logic [8:0] x, input logic [8:0] y);
		int unsigned sum [3];
		logic [7:0] idx;
		logic [23:0] rgb;
		bit clear;
		ptbd_pkg::out_item_t px;
		sum = '{0, 0, 0};
		clear = 1'b1;
		sample_addrs(x, y);
		for (int k = 0; k < 4; k++) begin
			idx = src_mem[tex_addr[k]];
			rgb = pal_mem[idx];
			for (int ch = 0; ch < 3; ch++)
				sum[ch] += 32'(rgb[8*ch +: 8]);
			if (idx != sh_trans) clear = 1'b0;
		end
		px.red = 8'(sum[0] >> 2);
		px.green = 8'(sum[1] >> 2);
		px.blue = 8'(sum[2] >> 2);
		px.alpha = (sh_mask && clear) ? 8'h00 : 8'hFF;
		pix_expected.insert(pix_expected.size(), px);
	endtask

	// Send one beat on the input channel and update the shadow on acceptance.
	task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
			input logic [23:0] val, input logic [8:0] x, input logic [8:0] y);
		if (!quiet && $urandom_range(99) < 35) begin
			in_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_data = '{op: op, write_address: addr, write_value: val, out_x: x, out_y: y};
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		case (op)
			ptbd_pkg::OpPal: begin
				pal_mem[addr[7:0]] = val;
				pal_set[addr[7:0]] = 1'b1;
			end
			ptbd_pkg::OpSrc: begin
				src_mem[addr] = val[7:0];
				src_set[addr] = 1'b1;
			end
			ptbd_pkg::OpPix: predict_pixel(x, y);
			default: ;
		endcase
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Write one configuration register.
	task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ptbd_pkg::RegSrcW: sh_src_w = val;
			ptbd_pkg::RegSrcH: sh_src_h = val;
			ptbd_pkg::RegDstW: sh_dst_w = val;
			ptbd_pkg::RegDstH: sh_dst_h = val;
			ptbd_pkg::RegMask: sh_mask = val[0];
			ptbd_pkg::RegTrans: sh_trans = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until every expected pixel has come out and loads have drained.
	task automatic wait_idle();
		while (pix_expected.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_sizes(input logic [9:0] sw, input logic [9:0] sh,
			input logic [9:0] tw, input logic [9:0] th);
		wait_idle();
		write_reg(ptbd_pkg::RegSrcW, sw);
		write_reg(ptbd_pkg::RegSrcH, sh);
		write_reg(ptbd_pkg::RegDstW, tw);
		write_reg(ptbd_pkg::RegDstH, th);
	endtask

	// Load any texel or palette entry that pixel (x, y) needs, then compute it.
	// With trans set, every texel of the footprint takes the transparent index.
	task automatic compute_pixel(input logic [8:0] x, input logic [8:0] y, input bit trans);
		logic [7:0] idx;
		sample_addrs(x, y);
		for (int k = 0; k < 4; k++) begin
			if (trans || !src_set[tex_addr[k]]) begin
				idx = trans ? sh_trans : 8'($urandom_range(255));
				send_item(ptbd_pkg::OpSrc, 16'(tex_addr[k]), {16'($urandom), idx},
					9'($urandom), 9'($urandom));
			end
		end
		for (int k = 0; k < 4; k++) begin
			idx = src_mem[tex_addr[k]];
			if (!pal_set[idx])
				send_item(ptbd_pkg::OpPal, {8'($urandom), idx}, 24'($urandom),
					9'($urandom), 9'($urandom));
		end
		send_item(ptbd_pkg::OpPix, 16'($urandom), 24'($urandom), x, y);
	endtask

	task automatic report_mismatch(input string msg);
		$display("%s at %0t", msg, $realtime);
		errors++;
	endtask

	// Output side stalls at random.
	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 35);

	// Compare each output beat with the oldest expected pixel.
	always @(posedge clk) begin
		ptbd_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pix_expected.size() == 0) begin
				report_mismatch("unexpected output beat");
			end else begin
				want = pix_expected.pop_front();
				if (out_data.red !== want.red)
					report_mismatch($sformatf("mismatch on red: expected %0d, got %0d",
						want.red, out_data.red));
				if (out_data.green !== want.green)
					report_mismatch($sformatf("mismatch on green: expected %0d, got %0d",
						want.green, out_data.green));
				if (out_data.blue !== want.blue)
					report_mismatch($sformatf("mismatch on blue: expected %0d, got %0d",
						want.blue, out_data.blue));
				if (out_data.alpha !== want.alpha)
					report_mismatch($sformatf("mismatch on alpha: expected %0d, got %0d",
						want.alpha, out_data.alpha));
			end
		end
	end

	// Reset values, then the one-texel image.
	task automatic test_reset_defaults();
		compute_pixel(9'd0, 9'd0, 1'b0);
		compute_pixel(9'h1FF, 9'h1FF, 1'b0);
		send_item(ptbd_pkg::OpNop, 16'hFFFF, 24'hFFFFFF, 9'h1FF, 9'h1FF);
	endtask

	// Largest image with address wrap, out-of-range sizes and coordinates.
	task automatic test_size_extremes();
		set_sizes(10'd512, 10'd512, 10'd512, 10'd512);
		compute_pixel(9'd0, 9'd0, 1'b0);
		compute_pixel(9'd511, 9'd511, 1'b0);
		compute_pixel(9'd511, 9'd0, 1'b0);
		send_item(ptbd_pkg::OpSrc, 16'hFFFF, 24'hABCD12, 9'd0, 9'd0);
		send_item(ptbd_pkg::OpPal, 16'hFF12, 24'hFFFFFF, 9'd0, 9'd0);
		set_sizes(10'h3FF, 10'd0, 10'd0, 10'h3FF);
		compute_pixel(9'd300, 9'd7, 1'b0);
		compute_pixel(9'h1FF, 9'h1FF, 1'b0);
		set_sizes(10'd3, 10'd5, 10'd2, 10'd1);
		compute_pixel(9'd1, 9'd200, 1'b0);
		compute_pixel(9'h1FF, 9'd0, 1'b0);
	endtask

	// Fully transparent footprint with masking on and off.
	task automatic test_masking();
		set_sizes(10'd4, 10'd4, 10'd2, 10'd2);
		write_reg(ptbd_pkg::RegTrans, 10'h3A5);
		write_reg(ptbd_pkg::RegMask, 10'h3FF);
		compute_pixel(9'd0, 9'd0, 1'b1);
		compute_pixel(9'd1, 9'd1, 1'b0);
		wait_idle();
		write_reg(ptbd_pkg::RegMask, 10'd0);
		compute_pixel(9'd0, 9'd0, 1'b1);
		wait_idle();
		write_reg(ptbd_pkg::RegTrans, 10'd0);
		write_reg(ptbd_pkg::RegMask, 10'd1);
		compute_pixel(9'd0, 9'd0, 1'b0);
	endtask

	// Random phases: fresh settings, then mostly pixels with some load noise.
	task automatic test_random();
		int kind;
		logic [9:0] dims [4];
		for (int phase = 0; sent < 1200; phase++) begin
			quiet = (phase == 1);
			for (int k = 0; k < 4; k++) begin
				kind = $urandom_range(19);
				dims[k] = (kind == 0) ? 10'd512 : (kind == 1) ? 10'($urandom) :
					(kind == 2) ? 10'd0 : 10'($urandom_range(24, 1));
			end
			set_sizes(dims[0], dims[1], dims[2], dims[3]);
			write_reg(ptbd_pkg::RegMask, 10'($urandom));
			write_reg(ptbd_pkg::RegTrans, 10'($urandom));
			for (int i = 0; i < 80 && sent < 1200; i++) begin
				kind = $urandom_range(99);
				if (kind < 70)
					compute_pixel(($urandom_range(9) == 0) ? 9'($urandom) :
						9'($urandom_range(fit_dim(sh_dst_w) - 1)),
						($urandom_range(9) == 0) ? 9'($urandom) :
						9'($urandom_range(fit_dim(sh_dst_h) - 1)),
						$urandom_range(2) == 0);
				else if (kind < 85)
					send_item(ptbd_pkg::OpSrc, 16'($urandom), 24'($urandom),
						9'($urandom), 9'($urandom));
				else if (kind < 95)
					send_item(ptbd_pkg::OpPal, 16'($urandom), 24'($urandom),
						9'($urandom), 9'($urandom));
				else
					send_item(ptbd_pkg::OpNop, 16'($urandom), 24'($urandom),
						9'($urandom), 9'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		sh_src_w = 10'd1;
		sh_src_h = 10'd1;
		sh_dst_w = 10'd1;
		sh_dst_h = 10'd1;
		sh_mask = 1'b0;
		sh_trans = 8'd255;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_size_extremes();
		test_masking();
		test_random();
		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#30ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

/* palette_texture_box_downscale_core.f */
rtl/core/ptbd_pkg.sv
rtl/core/ptbd_front.sv
rtl/core/ptbd_div.sv
rtl/core/ptbd_back.sv
rtl/core/palette_texture_box_downscale_core.sv
tb/tb.sv
